// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition that must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== hdl/grt_pkg.sv =====
`timescale 1ns / 1ps
package grt_pkg;

  // Stick lanes: left X, left Y, right X, right Y
  localparam int NumAxes = 4;

  // Queue between classifier and scaler
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Accepted report identifiers
  localparam logic [7:0] TypeUsb = 8'h30;
  localparam logic [7:0] TypeBt  = 8'h3F;

  // Stick centring offsets and lower range bounds (bounds as positive shift)
  localparam logic [7:0]         OffUsb  = 8'd127;
  localparam logic [15:0]        OffBt   = 16'd32767;
  localparam logic signed [16:0] ShiftUsb = 17'sd100;
  localparam logic signed [16:0] ShiftBt  = 17'sd25000;

  // Span of each source range
  localparam logic [15:0] DivUsbX = 16'd185;
  localparam logic [15:0] DivUsbY = 16'd190;
  localparam logic [15:0] DivBtX  = 16'd47000;
  localparam logic [15:0] DivBtY  = 16'd48000;

  // Reciprocals: floor(65535 * 2^16 / span)
  localparam int MulW = 25;
  localparam logic [63:0] FullScale = 64'd65535 << 16;
  localparam logic [MulW-1:0] MulUsbX = MulW'(FullScale / 64'(DivUsbX));
  localparam logic [MulW-1:0] MulUsbY = MulW'(FullScale / 64'(DivUsbY));
  localparam logic [MulW-1:0] MulBtX  = MulW'(FullScale / 64'(DivBtX));
  localparam logic [MulW-1:0] MulBtY  = MulW'(FullScale / 64'(DivBtY));

  // Output button bit positions
  localparam int BitUp     = 0;
  localparam int BitDown   = 1;
  localparam int BitLeft   = 2;
  localparam int BitRight  = 3;
  localparam int BitStart  = 4;
  localparam int BitBack   = 5;
  localparam int BitLThumb = 6;
  localparam int BitRThumb = 7;
  localparam int BitLShldr = 8;
  localparam int BitRShldr = 9;
  localparam int BitGuide  = 10;
  localparam int BitA      = 12;
  localparam int BitB      = 13;
  localparam int BitX      = 14;
  localparam int BitY      = 15;

  typedef struct packed {
    logic        mode;
    logic [15:0] buttons;
    logic        ltrig;
    logic        rtrig;
  } grt_side_t;

  // One classified request: sidebands plus offset stick magnitudes and signs
  typedef struct packed {
    grt_side_t                    side;
    logic [NumAxes-1:0][15:0]     mag;
    logic [NumAxes-1:0]           neg;
  } grt_item_t;

  // Output report, buttons in the lowest bits
  typedef struct packed {
    logic [NumAxes-1:0][15:0] thumb;
    logic [7:0]               rtrig;
    logic [7:0]               ltrig;
    logic [15:0]              buttons;
  } grt_report_t;

  // Direction pad bits for an eight-way hat code
  function automatic logic [15:0] hat_mask(input logic [7:0] hat);
    logic [15:0] m;
    m = '0;
    case (hat)
      8'd0: m[BitUp] = 1'b1;
      8'd1: begin
        m[BitUp] = 1'b1;
        m[BitRight] = 1'b1;
      end
      8'd2: m[BitRight] = 1'b1;
      8'd3: begin
        m[BitRight] = 1'b1;
        m[BitDown] = 1'b1;
      end
      8'd4: m[BitDown] = 1'b1;
      8'd5: begin
        m[BitDown] = 1'b1;
        m[BitLeft] = 1'b1;
      end
      8'd6: m[BitLeft] = 1'b1;
      8'd7: begin
        m[BitLeft] = 1'b1;
        m[BitUp] = 1'b1;
      end
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] axis_div(input logic mode, input logic is_y);
    logic [15:0] d;
    case ({mode, is_y})
      2'b00:   d = DivUsbX;
      2'b01:   d = DivUsbY;
      2'b10:   d = DivBtX;
      default: d = DivBtY;
    endcase
    return d;
  endfunction

  function automatic logic [MulW-1:0] axis_mul(input logic mode, input logic is_y);
    logic [MulW-1:0] m;
    case ({mode, is_y})
      2'b00:   m = MulUsbX;
      2'b01:   m = MulUsbY;
      2'b10:   m = MulBtX;
      default: m = MulBtY;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/grt_front.sv =====
`timescale 1ns / 1ps
module grt_front (
  input  logic              s_axis_tvalid,
  input  logic              ready_i,
  // tdata: report_type, button_bits, hat_code, usb_stick_bytes,
  //        bt_left_x, bt_left_y, bt_right_x, bt_right_y
  input  logic [159:0]      s_axis_tdata,
  // tuser: mode
  input  logic              s_axis_tuser,
  output logic              push_o,
  output grt_pkg::grt_item_t item_o
);
  import grt_pkg::*;

  logic [7:0]  rtype;
  logic [31:0] bb;
  logic [7:0]  hat;
  logic [47:0] sb;
  logic [NumAxes-1:0][15:0] bt_raw;
  logic        type_ok;

  // Unpack the request fields
  assign rtype     = s_axis_tdata[7:0];
  assign bb        = s_axis_tdata[39:8];
  assign hat       = s_axis_tdata[47:40];
  assign sb        = s_axis_tdata[95:48];
  assign bt_raw[0] = s_axis_tdata[111:96];
  assign bt_raw[1] = s_axis_tdata[127:112];
  assign bt_raw[2] = s_axis_tdata[143:128];
  assign bt_raw[3] = s_axis_tdata[159:144];

  assign type_ok = s_axis_tuser ? (rtype == TypeBt) : (rtype == TypeUsb);
  // Drop requests of the wrong report type here
  assign push_o  = s_axis_tvalid && ready_i && type_ok;

  always_comb begin
    logic [15:0]             b;
    logic [NumAxes-1:0][7:0] usb_raw;
    logic [7:0]              ub;
    logic [15:0]             bw;
    logic signed [16:0]      a;
    // Map buttons and triggers
    b = '0;
    if (!s_axis_tuser) begin
      b[BitB]      = bb[11];
      b[BitA]      = bb[10];
      b[BitY]      = bb[9];
      b[BitX]      = bb[8];
      b[BitUp]     = bb[25];
      b[BitDown]   = bb[24];
      b[BitLeft]   = bb[27];
      b[BitRight]  = bb[26];
      b[BitStart]  = bb[17];
      b[BitBack]   = bb[16];
      b[BitGuide]  = bb[20];
      b[BitLShldr] = bb[30];
      b[BitLThumb] = bb[19];
      b[BitRShldr] = bb[14];
      b[BitRThumb] = bb[18];
      item_o.side.ltrig = bb[31];
      item_o.side.rtrig = bb[15];
    end else begin
      b[BitB]      = bb[1];
      b[BitA]      = bb[0];
      b[BitY]      = bb[3];
      b[BitX]      = bb[2];
      b[BitStart]  = bb[9];
      b[BitBack]   = bb[8];
      b[BitGuide]  = bb[12];
      b[BitLShldr] = bb[4];
      b[BitLThumb] = bb[10];
      b[BitRShldr] = bb[5];
      b[BitRThumb] = bb[11];
      b = b | hat_mask(hat);
      item_o.side.ltrig = bb[6];
      item_o.side.rtrig = bb[7];
    end
    item_o.side.buttons = b;
    item_o.side.mode    = s_axis_tuser;

    // Unpack, centre and shift each stick into a sign and a magnitude
    usb_raw[0] = {sb[11:8], sb[7:4]};
    usb_raw[1] = sb[23:16];
    usb_raw[2] = {sb[35:32], sb[31:28]};
    usb_raw[3] = sb[47:40];
    for (int i = 0; i < NumAxes; i++) begin
      ub = usb_raw[i] + OffUsb;
      bw = bt_raw[i] + OffBt;
      // Bluetooth Y axes point the other way
      if (i[0]) begin
        bw = 16'(16'd0 - bw);
      end
      if (s_axis_tuser) begin
        a = 17'(signed'(bw)) + ShiftBt;
      end else begin
        a = 17'(signed'(ub)) + ShiftUsb;
      end
      if (a < 0) begin
        item_o.neg[i] = 1'b1;
        item_o.mag[i] = 16'(-a);
      end else begin
        item_o.neg[i] = 1'b0;
        item_o.mag[i] = a[15:0];
      end
    end
  end

endmodule

// ===== hdl/grt_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module grt_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  grt_pkg::grt_item_t push_data_i,
  output logic               ready_o,
  output logic               valid_o,
  output grt_pkg::grt_item_t data_o,
  input  logic               pop_i
);
  import grt_pkg::*;

  grt_item_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the request at the write pointer
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ASSERT_NEVER(a_q_overflow, clk_i, rst_ni, (cnt_q == QCntW'(QDepth)) && push_i, "queue overflow")
  `ASSERT_NEVER(a_q_underflow, clk_i, rst_ni, (cnt_q == '0) && pop_i, "queue underflow")
  `ASSERT_PROP(a_q_count, clk_i, rst_ni, cnt_q[QPtrW-1:0] == QPtrW'(wr_ptr_q - rd_ptr_q), "queue count mismatch")

endmodule

// ===== hdl/grt_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module grt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  grt_pkg::grt_item_t q_data_i,
  output logic               q_pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // tdata: pad_buttons, left_trigger, right_trigger, thumb_left_x,
  //        thumb_left_y, thumb_right_x, thumb_right_y
  output logic [95:0]        m_axis_tdata
);
  import grt_pkg::*;

  logic en;

  // Stage 1: reciprocal product and scaled numerator
  logic                     v1_q;
  grt_side_t                side1_q;
  logic [NumAxes-1:0]       neg1_q;
  logic [NumAxes-1:0][16:0] q01_q, q01_d;
  logic [NumAxes-1:0][31:0] n1_q, n1_d;

  // Stage 2: back-multiply of the estimate
  logic                     v2_q;
  grt_side_t                side2_q;
  logic [NumAxes-1:0]       neg2_q;
  logic [NumAxes-1:0][16:0] q02_q;
  logic [NumAxes-1:0][31:0] n2_q;
  logic [NumAxes-1:0][31:0] t2_q, t2_d;

  // Stage 3: corrected quotient
  logic                     v3_q;
  grt_side_t                side3_q;
  logic [NumAxes-1:0]       neg3_q;
  logic [NumAxes-1:0][16:0] q3_q, q3_d;

  // Stage 4: finished report
  logic                     v4_q;
  grt_report_t              rep4_q, rep4_d;

  // Output register and last emitted report
  logic                     out_valid_q;
  grt_report_t              out_q;
  grt_report_t              prev_q;
  logic                     changed;

  // Whole pipeline advances when the output register is free
  assign en      = !out_valid_q || m_axis_tready;
  assign q_pop_o = en && q_valid_i;

  always_comb begin
    logic [40:0] prod;
    for (int i = 0; i < NumAxes; i++) begin
      prod     = 41'(q_data_i.mag[i]) * 41'(axis_mul(q_data_i.side.mode, i[0]));
      q01_d[i] = prod[32:16];
      n1_d[i]  = {q_data_i.mag[i], 16'd0} - 32'(q_data_i.mag[i]);
    end
  end

  always_comb begin
    logic [32:0] tw;
    for (int i = 0; i < NumAxes; i++) begin
      tw      = 33'(q01_q[i]) * 33'(axis_div(side1_q.mode, i[0]));
      t2_d[i] = tw[31:0];
    end
  end

  // Add one where the remainder still holds a whole span
  always_comb begin
    logic [31:0] r;
    for (int i = 0; i < NumAxes; i++) begin
      r = n2_q[i] - t2_q[i];
      if (r >= 32'(axis_div(side2_q.mode, i[0]))) begin
        q3_d[i] = q02_q[i] + 17'd1;
      end else begin
        q3_d[i] = q02_q[i];
      end
    end
  end

  // Apply sign, recentre and saturate
  always_comb begin
    logic signed [18:0] s;
    for (int i = 0; i < NumAxes; i++) begin
      if (neg3_q[i]) begin
        s = -signed'({2'b00, q3_q[i]});
      end else begin
        s = signed'({2'b00, q3_q[i]});
      end
      s = s - 19'sd32768;
      if (s > 19'sd32767) begin
        rep4_d.thumb[i] = 16'h7FFF;
      end else if (s < -19'sd32768) begin
        rep4_d.thumb[i] = 16'h8000;
      end else begin
        rep4_d.thumb[i] = s[15:0];
      end
    end
    rep4_d.buttons = side3_q.buttons;
    rep4_d.ltrig   = side3_q.ltrig ? 8'hFF : 8'h00;
    rep4_d.rtrig   = side3_q.rtrig ? 8'hFF : 8'h00;
  end

  assign changed = (rep4_q != prev_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
    end else if (en) begin
      v1_q        <= q_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      // Emit only a report that differs from the last one emitted
      out_valid_q <= v4_q && changed;
      if (v4_q && changed) begin
        prev_q <= rep4_q;
      end
    end
  end

  // Payload moves with the pipeline
  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= q_data_i.side;
      neg1_q  <= q_data_i.neg;
      q01_q   <= q01_d;
      n1_q    <= n1_d;
      side2_q <= side1_q;
      neg2_q  <= neg1_q;
      q02_q   <= q01_q;
      n2_q    <= n1_q;
      t2_q    <= t2_d;
      side3_q <= side2_q;
      neg3_q  <= neg2_q;
      q3_q    <= q3_d;
      rep4_q  <= rep4_d;
      out_q   <= rep4_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  `ASSERT_PROP(a_out_is_state, clk_i, rst_ni, out_valid_q |-> (out_q == prev_q), "output differs from stored report")
  `ASSERT_PROP(a_new_emitted, clk_i, rst_ni, (en && v4_q && changed) |=> out_valid_q, "changed report not emitted")
  `ASSERT_PROP(a_dup_dropped, clk_i, rst_ni, (en && v4_q && !changed) |=> !out_valid_q, "repeated report emitted")

endmodule

// ===== hdl/gamepad_report_translator.sv =====
// Path from input acceptance to m_axis_tvalid: queue, four scaling stages, output register.
// Throughput: one request per cycle while m_axis_tready does not stall the output register.
// Wrong report types and reports equal to the last emitted one give no output.
// Reset (rst_ni low, asynchronous) empties the queue and pipeline and clears the stored report.
`timescale 1ns / 1ps
module gamepad_report_translator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: report_type, button_bits, hat_code, usb_stick_bytes,
  //        bt_left_x, bt_left_y, bt_right_x, bt_right_y
  input  logic [159:0] s_axis_tdata,
  // tuser: mode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: pad_buttons, left_trigger, right_trigger, thumb_left_x,
  //        thumb_left_y, thumb_right_x, thumb_right_y
  output logic [95:0]  m_axis_tdata
);
  import grt_pkg::*;

  logic      push;
  grt_item_t push_item;
  logic      q_valid;
  logic      q_pop;
  grt_item_t q_item;

  // Classify and unpack requests
  grt_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .ready_i       (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_o        (push),
    .item_o        (push_item)
  );

  // Decouple front from scaler
  grt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .ready_o     (s_axis_tready),
    .valid_o     (q_valid),
    .data_o      (q_item),
    .pop_i       (q_pop)
  );

  // Scale sticks, filter repeats, hold output
  grt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_item),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
